// ===== sv/spr_pkg.sv =====
`default_nettype none
package spr_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 12;

    localparam int FIELD_COORD_W   = 12;
    localparam int SPACING_W       = 12;
    localparam int TARGET_W        = 7;
    localparam int COUNT_OUT_W     = 7;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 12;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 12'd16;
    localparam logic [TARGET_W-1:0]  TARGET_RESET  = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_SPACING  = 2'd0,
        REG_TARGET_COUNT = 2'd1
    } cfg_reg_t;

    localparam logic ACTION_OFFER = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [FIELD_COORD_W-1:0] cand_x;
        logic [FIELD_COORD_W-1:0] cand_y;
    } in_item_t;

    typedef struct packed {
        logic                   accepted;
        logic [COUNT_OUT_W-1:0] accepted_count;
        logic                   done_res;
    } out_item_t;

    typedef struct packed {
        logic cap_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/spr_cell.sv =====
`default_nettype none
module spr_cell #(
    parameter int COORD_BITS = spr_pkg::COORD_BITS_DEF
) (
    input  wire                               aclk,
    input  wire  spr_pkg::cell_ctrl_t         ctrl,
    input  wire                               active,
    input  wire  [spr_pkg::SPACING_W-1:0]     min_spacing,
    input  wire  [COORD_BITS-1:0]             cmp_x,
    input  wire  [COORD_BITS-1:0]             cmp_y,
    input  wire  [COORD_BITS-1:0]             in_x,
    input  wire  [COORD_BITS-1:0]             in_y,
    output logic [COORD_BITS-1:0]             out_x,
    output logic [COORD_BITS-1:0]             out_y,
    output logic                              hit
);

    localparam int CMP_W = (COORD_BITS > spr_pkg::SPACING_W) ? COORD_BITS : spr_pkg::SPACING_W;

    logic [COORD_BITS-1:0] pt_x_reg;
    logic [COORD_BITS-1:0] pt_y_reg;
    logic                  hit_reg;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  hit_next;

    always_comb begin
        dx = (cmp_x >= pt_x_reg) ? (cmp_x - pt_x_reg) : (pt_x_reg - cmp_x);
        dy = (cmp_y >= pt_y_reg) ? (cmp_y - pt_y_reg) : (pt_y_reg - cmp_y);
        hit_next = active
                 && (CMP_W'(dx) <= CMP_W'(min_spacing))
                 && (CMP_W'(dy) <= CMP_W'(min_spacing));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cap_en) begin
            hit_reg <= hit_next;
        end
        // advance the point one cell down the row on append
        if (ctrl.shift_en) begin
            pt_x_reg <= in_x;
            pt_y_reg <= in_y;
        end
    end

    assign out_x = pt_x_reg;
    assign out_y = pt_y_reg;
    assign hit   = hit_reg;

endmodule
`default_nettype wire

// ===== sv/spr_chain.sv =====
`default_nettype none
module spr_chain #(
    parameter int MAX_POINTS = spr_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = spr_pkg::COORD_BITS_DEF,
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  wire                            aclk,
    input  wire  spr_pkg::cell_ctrl_t      ctrl,
    input  wire  [CNT_W-1:0]               count,
    input  wire  [spr_pkg::SPACING_W-1:0]  min_spacing,
    input  wire  [COORD_BITS-1:0]          cmp_x,
    input  wire  [COORD_BITS-1:0]          cmp_y,
    input  wire  [COORD_BITS-1:0]          new_x,
    input  wire  [COORD_BITS-1:0]          new_y,
    output logic                           any_hit
);

    logic [COORD_BITS-1:0] link_x [MAX_POINTS+1];
    logic [COORD_BITS-1:0] link_y [MAX_POINTS+1];
    logic [MAX_POINTS-1:0] hits;
    logic [MAX_POINTS-1:0] active;

    assign link_x[0] = new_x;
    assign link_y[0] = new_y;

    // the newest point sits in cell 0, so the first count cells hold the list
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        assign active[i] = CNT_W'(i) < count;

        spr_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .active      (active[i]),
            .min_spacing (min_spacing),
            .cmp_x       (cmp_x),
            .cmp_y       (cmp_y),
            .in_x        (link_x[i]),
            .in_y        (link_y[i]),
            .out_x       (link_x[i+1]),
            .out_y       (link_y[i+1]),
            .hit         (hits[i])
        );
    end

    assign any_hit = |hits;

endmodule
`default_nettype wire

// ===== sv/spaced_point_rejection_filter.sv =====
// Order: cell compares are registered at input accept; the OR of all cell
//   hits, the list update and the result register follow in the update step.
// Flow: a new request is taken only once the last one has finished;
//   a result waiting on m_ready stalls the update step and the next request.
// Reset: stored count cleared, min_spacing = 16, target_count = 64; the
//   point cells are not cleared, only cells below the count take part.
`default_nettype none
module spaced_point_rejection_filter #(
    parameter int MAX_POINTS = spr_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = spr_pkg::COORD_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  spr_pkg::in_item_t            s_data,
    output logic                               m_valid,
    input  wire                                m_ready,
    output spr_pkg::out_item_t                 m_data,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [spr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [spr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int TW     = (CNT_W > spr_pkg::TARGET_W) ? CNT_W : spr_pkg::TARGET_W;
    localparam int WIDE_W = (COORD_BITS > spr_pkg::FIELD_COORD_W) ?
                            COORD_BITS : spr_pkg::FIELD_COORD_W;

    logic [spr_pkg::SPACING_W-1:0] spacing_reg;
    logic [spr_pkg::TARGET_W-1:0]  target_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          busy_reg;
    logic                          action_reg;
    logic [COORD_BITS-1:0]         cand_x_reg;
    logic [COORD_BITS-1:0]         cand_y_reg;
    logic                          m_valid_reg;
    spr_pkg::out_item_t            m_data_reg;
    spr_pkg::out_item_t            m_data_next;

    logic [WIDE_W-1:0]     wide_x;
    logic [WIDE_W-1:0]     wide_y;
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    logic                  in_fire;
    logic                  finish;
    logic                  any_hit;
    logic                  acc;
    logic [TW-1:0]         eff_tgt;
    spr_pkg::cell_ctrl_t   ctrl;

    assign wide_x = WIDE_W'(s_data.cand_x);
    assign wide_y = WIDE_W'(s_data.cand_y);
    assign in_x   = wide_x[COORD_BITS-1:0];
    assign in_y   = wide_y[COORD_BITS-1:0];

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign finish    = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        eff_tgt = (TW'(target_reg) > TW'(MAX_POINTS)) ? TW'(MAX_POINTS) : TW'(target_reg);
        acc = (action_reg == spr_pkg::ACTION_OFFER)
           && (TW'(count_reg) < eff_tgt)
           && !any_hit;
        if (action_reg == spr_pkg::ACTION_CLEAR) begin
            count_next = '0;
        end else if (acc) begin
            count_next = count_reg + CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
        m_data_next.accepted       = acc;
        m_data_next.accepted_count = spr_pkg::COUNT_OUT_W'(count_next);
        m_data_next.done_res       = TW'(count_next) >= eff_tgt;
        ctrl.cap_en   = in_fire;
        ctrl.shift_en = finish && acc;
    end

    spr_chain #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W)
    ) u_chain (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .count       (count_reg),
        .min_spacing (spacing_reg),
        .cmp_x       (in_x),
        .cmp_y       (in_y),
        .new_x       (cand_x_reg),
        .new_y       (cand_y_reg),
        .any_hit     (any_hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= spr_pkg::SPACING_RESET;
            target_reg  <= spr_pkg::TARGET_RESET;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    spr_pkg::REG_MIN_SPACING:  spacing_reg <= cfg_data[spr_pkg::SPACING_W-1:0];
                    spr_pkg::REG_TARGET_COUNT: target_reg  <= cfg_data[spr_pkg::TARGET_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                busy_reg <= 1'b1;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
            if (finish) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the request for the list update once the cells have compared it
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            action_reg <= s_data.action;
            cand_x_reg <= in_x;
            cand_y_reg <= in_y;
        end
        if (finish) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        TW'(count_reg) <= TW'(MAX_POINTS))
        else $error("stored count above capacity");

    a_accept_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && acc) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted point did not advance count");

    a_result_after_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (m_valid && !busy_reg))
        else $error("finished request produced no result");
`endif

endmodule
`default_nettype wire

// ===== test/tb_spaced_point_rejection_filter.sv =====
module tb_spaced_point_rejection_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;

    localparam int CAPACITY     = MAX_POINTS_DEF;
    localparam int COORD_MAX    = (1 << FIELD_COORD_W) - 1;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 1000;

    class spacing_scoreboard;
        logic [FIELD_COORD_W-1:0] px [CAPACITY];
        logic [FIELD_COORD_W-1:0] py [CAPACITY];
        int                       stored;
        logic [SPACING_W-1:0]     spacing;
        logic [TARGET_W-1:0]      target;
        out_item_t                pending_verdicts [$];
        int                       errors;
        int                       n_stored;
        int                       n_rejected;
        int                       n_cleared;
        int                       n_ignored;

        function new();
            stored     = 0;
            spacing    = SPACING_RESET;
            target     = TARGET_RESET;
            errors     = 0;
            n_stored   = 0;
            n_rejected = 0;
            n_cleared  = 0;
            n_ignored  = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MIN_SPACING:  spacing = data[SPACING_W-1:0];
                REG_TARGET_COUNT: target  = data[TARGET_W-1:0];
                default: ;
            endcase
        endfunction

        // a target above capacity acts as full capacity
        function int goal();
            return (int'(target) > CAPACITY) ? CAPACITY : int'(target);
        endfunction

        function bit finished();
            return stored >= goal();
        endfunction

        function bit near_stored(logic [FIELD_COORD_W-1:0] x, logic [FIELD_COORD_W-1:0] y);
            int dx;
            int dy;
            for (int i = 0; i < stored; i++) begin
                dx = int'(x) - int'(px[i]);
                dy = int'(y) - int'(py[i]);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx <= int'(spacing) && dy <= int'(spacing)) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(in_item_t item);
            out_item_t verdict;
            verdict.accepted = 1'b0;
            if (item.action == ACTION_CLEAR) begin
                stored = 0;
                n_cleared++;
            end else if (finished()) begin
                n_ignored++;
            end else if (near_stored(item.cand_x, item.cand_y)) begin
                n_rejected++;
            end else begin
                px[stored] = item.cand_x;
                py[stored] = item.cand_y;
                stored++;
                verdict.accepted = 1'b1;
                n_stored++;
            end
            verdict.accepted_count = COUNT_OUT_W'(stored);
            verdict.done_res       = finished();
            pending_verdicts.push_back(verdict);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0b/%0d/%0b", $time,
                         got.accepted, got.accepted_count, got.done_res);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.accepted !== want.accepted) begin
                errors++;
                $display("%0t: accepted: expected %0b, actual %0b", $time,
                         want.accepted, got.accepted);
            end
            if (got.accepted_count !== want.accepted_count) begin
                errors++;
                $display("%0t: accepted_count: expected %0d, actual %0d", $time,
                         want.accepted_count, got.accepted_count);
            end
            if (got.done_res !== want.done_res) begin
                errors++;
                $display("%0t: done_res: expected %0b, actual %0b", $time,
                         want.done_res, got.done_res);
            end
        endfunction

        function bit pick_stored(output logic [FIELD_COORD_W-1:0] x,
                                 output logic [FIELD_COORD_W-1:0] y);
            int k;
            x = '0;
            y = '0;
            if (stored == 0) return 1'b0;
            k = $urandom_range(0, stored - 1);
            x = px[k];
            y = py[k];
            return 1'b1;
        endfunction

        function int live_items();
            return n_stored + n_rejected + n_cleared + n_ignored;
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_SPACING;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    spacing_scoreboard board;
    int                n_settings  = 0;
    int                quiet_count = 0;
    int                rx_mode     = 0;
    int                rx_run      = 0;

    spaced_point_rejection_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: switch between free flow, light, heavy and coin-flip stalls
    always @(posedge aclk) begin
        if (rx_run == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_run  <= $urandom_range(16, 200);
        end else begin
            rx_run <= rx_run - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= (rx_run[2:0] == 3'd0);
            default: m_ready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb_spaced_point_rejection_filter failed");
            $finish;
        end
    end

    function automatic in_item_t point(logic action, int x, int y);
        in_item_t item;
        item.action = action;
        item.cand_x = FIELD_COORD_W'(x);
        item.cand_y = FIELD_COORD_W'(y);
        return item;
    endfunction

    // land on, just past or anywhere within the spacing boundary of a stored coordinate
    function automatic logic [FIELD_COORD_W-1:0] nudge(logic [FIELD_COORD_W-1:0] base, int sp);
        int off;
        int v;
        case ($urandom_range(0, 4))
            0:       off = sp;
            1:       off = sp + 1;
            2:       off = -sp;
            3:       off = -sp - 1;
            default: off = int'($urandom_range(0, 2 * sp)) - sp;
        endcase
        v = int'(base) + off;
        if (v < 0 || v > COORD_MAX) v = int'(base) - off;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return FIELD_COORD_W'(v);
    endfunction

    function automatic in_item_t make_candidate();
        in_item_t                 item;
        logic [FIELD_COORD_W-1:0] bx;
        logic [FIELD_COORD_W-1:0] by;
        int                       pick;
        item.action = ACTION_OFFER;
        item.cand_x = FIELD_COORD_W'($urandom_range(0, COORD_MAX));
        item.cand_y = FIELD_COORD_W'($urandom_range(0, COORD_MAX));
        pick = $urandom_range(0, 99);
        // clear often once the list is full so few offers are ignored
        if (pick < (board.finished() ? 20 : 2)) begin
            item.action = ACTION_CLEAR;
        end else if (pick < 50) begin
            if (board.pick_stored(bx, by)) begin
                item.cand_x = nudge(bx, int'(board.spacing));
                item.cand_y = ($urandom_range(0, 3) == 0) ? by : nudge(by, int'(board.spacing));
            end
        end else if (pick < 56) begin
            item.cand_x = ($urandom_range(0, 1) != 0) ? FIELD_COORD_W'(COORD_MAX) : '0;
            item.cand_y = ($urandom_range(0, 1) != 0) ? FIELD_COORD_W'(COORD_MAX) : '0;
        end
        return item;
    endfunction

    // leave valid high on return so a burst can continue without a gap
    task automatic send_request(input in_item_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_request(item);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic set_regs(input int spacing, input int target);
        drain();
        cfg_write(REG_MIN_SPACING, CFG_DATA_W'(spacing));
        cfg_write(REG_TARGET_COUNT, CFG_DATA_W'(target));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int base;
        int phase_left;
        int burst;
        int spacing_pick;
        int target_pick;

        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: spacing 16, full list
        send_request(point(ACTION_OFFER, 0, 0));
        send_request(point(ACTION_OFFER, 16, 16));
        send_request(point(ACTION_OFFER, 17, 0));
        send_request(point(ACTION_OFFER, 0, 17));
        send_request(point(ACTION_OFFER, COORD_MAX, COORD_MAX));
        send_request(point(ACTION_OFFER, COORD_MAX - 16, COORD_MAX - 16));
        send_request(point(ACTION_CLEAR, COORD_MAX, COORD_MAX));
        send_request(point(ACTION_OFFER, 16, 16));

        // zero target: done at once, clear still reports done
        set_regs(0, 0);
        send_request(point(ACTION_OFFER, 100, 100));
        send_request(point(ACTION_CLEAR, 0, 0));

        // single point, then offers after done
        set_regs(0, 1);
        send_request(point(ACTION_OFFER, 5, 5));
        send_request(point(ACTION_OFFER, 5, 5));

        // target above capacity, zero spacing
        set_regs(0, 100);
        send_request(point(ACTION_OFFER, 5, 5));
        send_request(point(ACTION_OFFER, 6, 5));
        send_request(point(ACTION_OFFER, 6, 6));

        // lower the target below the stored count
        set_regs(0, 2);
        send_request(point(ACTION_OFFER, 1000, 1000));

        // widest spacing with the largest target code
        set_regs(COORD_MAX, 127);
        send_request(point(ACTION_CLEAR, 0, 0));
        send_request(point(ACTION_OFFER, 2048, 2048));
        send_request(point(ACTION_OFFER, 0, 0));
        send_request(point(ACTION_OFFER, COORD_MAX, 0));

        base = board.live_items();
        while (board.live_items() - base < RANDOM_ITEMS) begin
            spacing_pick = $urandom_range(0, 7);
            case (spacing_pick)
                0:       spacing_pick = 0;
                1:       spacing_pick = 1;
                2:       spacing_pick = COORD_MAX;
                3:       spacing_pick = 16;
                4, 5:    spacing_pick = $urandom_range(0, 40);
                6:       spacing_pick = $urandom_range(0, COORD_MAX);
                default: spacing_pick = $urandom_range(100, 600);
            endcase
            target_pick = $urandom_range(0, 15);
            case (target_pick)
                0:       target_pick = 0;
                1, 2:    target_pick = 1;
                3, 4:    target_pick = CAPACITY;
                5, 6:    target_pick = $urandom_range(CAPACITY + 1, 127);
                7, 8:    target_pick = $urandom_range(0, (1 << CFG_DATA_W) - 1);
                default: target_pick = $urandom_range(2, CAPACITY);
            endcase
            set_regs(spacing_pick, target_pick);

            phase_left = $urandom_range(40, 250);
            while (phase_left > 0 && board.live_items() - base < RANDOM_ITEMS) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(1, 24);
                repeat (burst) begin
                    if (phase_left > 0) begin
                        send_request(make_candidate());
                        phase_left--;
                    end
                end
                case ($urandom_range(0, 9))
                    0:       drain();
                    1, 2:    ;
                    default: pause_sender($urandom_range(1, 8));
                endcase
            end
        end

        drain();
        repeat (8) @(posedge aclk);

        $display("%0d requests under %0d register settings: %0d stored, %0d rejected,",
                 board.live_items(), n_settings, board.n_stored,
                 board.n_rejected);
        $display("%0d clears, %0d offers ignored on a finished list",
                 board.n_cleared, board.n_ignored);
        if (board.pending_verdicts.size() != 0)
            $display("%0t: %0d results never arrived", $time, board.pending_verdicts.size());
        if (board.errors == 0 && board.pending_verdicts.size() == 0) begin
            $display("tb_spaced_point_rejection_filter passed");
        end else begin
            $display("tb_spaced_point_rejection_filter failed");
        end
        $finish;
    end

endmodule
